// ----- design/cbe_pkg.sv -----
// Shared types and constants for the cubic Bezier easing evaluator.
package cbe_pkg;
	localparam int unsigned IterW = 5;
	localparam int unsigned TolW  = 16;
	localparam int unsigned IdxW  = 3;

	typedef enum logic [2:0] {
		REG_CTRL1_X      = 3'd0,
		REG_CTRL1_Y      = 3'd1,
		REG_CTRL2_X      = 3'd2,
		REG_CTRL2_Y      = 3'd3,
		REG_NEWTON_ITERS = 3'd4,
		REG_TOLERANCE    = 3'd5
	} reg_idx_t;

	// one step of the sequencer; in each multiply step the multiplier result lands in a register
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SS, ST_TT, ST_ST, ST_B1, ST_B2, ST_B3,
		ST_X1, ST_X2, ST_D1, ST_D2, ST_CHK,
		ST_DIV, ST_UPD,
		ST_Y1, ST_Y2, ST_YSUM,
		ST_OUT
	} state_t;
endpackage

// ----- design/cubic_bezier_easing_eval_unit.sv -----
// Cubic Bezier easing evaluator top level: Newton solve of x(t)=u, then y(t).
// Each item passes through one shared signed multiplier under a sequencer. A Newton
// step runs ten multiply states, one check state, a restoring divide over all
// 2*FRAC_BITS+8 dividend bits and one update state. The solve ends after n Newton updates
// (n <= newton_iters, capped at MAX_ITERS and at 31), or early when the error or derivative
// test stops it. Items with progress 0 or at least 1, or with newton_iters 0, skip the solve.
// The block takes one item at a time and is ready again as soon as the result is loaded;
// a result waits in the output register until taken, and the next item holds in its
// final sum state meanwhile.
module cubic_bezier_easing_eval_unit #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned MAX_ITERS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cbe_pkg::IdxW-1:0]     cfg_index,
	input  logic [FRAC_BITS+1:0]         cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [((FRAC_BITS+8)/8)*8-1:0] s_tdata,   // progress
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [((2*FRAC_BITS+10)/8)*8-1:0] m_tdata // eased_value, curve_param
);
	import cbe_pkg::*;

	localparam int unsigned XW = FRAC_BITS + 1;
	localparam int unsigned YW = FRAC_BITS + 2;
	localparam int unsigned AW = FRAC_BITS + 8;          // working signed width
	localparam int unsigned PW = 2 * AW;
	localparam int unsigned NW = 2 * FRAC_BITS + 8;      // dividend width
	localparam int unsigned DCW = $clog2(NW + 1);
	localparam int unsigned OUTW = ((2*FRAC_BITS+10)/8)*8;
	localparam int unsigned INW  = ((FRAC_BITS+8)/8)*8;
	localparam logic signed [AW-1:0] ONE = AW'(1) <<< FRAC_BITS;
	localparam logic signed [AW-1:0] YMAX = (ONE <<< 1) - AW'(1);
	localparam logic signed [AW-1:0] YMIN = -(ONE <<< 1);
	localparam logic [IterW-1:0] MAXI = IterW'(MAX_ITERS > 31 ? 31 : MAX_ITERS);

	logic [XW-1:0] c1x_q, c2x_q;
	logic [YW-1:0] c1y_q, c2y_q;
	logic [IterW-1:0] iters_q;
	logic [TolW-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1x_q <= '0;
			c1y_q <= '0;
			c2x_q <= XW'(1) << FRAC_BITS;
			c2y_q <= YW'(1) << FRAC_BITS;
			iters_q <= IterW'(8);
			tol_q <= TolW'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CTRL1_X:      c1x_q <= cfg_data[XW-1:0];
				REG_CTRL1_Y:      c1y_q <= cfg_data[YW-1:0];
				REG_CTRL2_X:      c2x_q <= cfg_data[XW-1:0];
				REG_CTRL2_Y:      c2y_q <= cfg_data[YW-1:0];
				REG_NEWTON_ITERS: iters_q <= cfg_data[IterW-1:0];
				REG_TOLERANCE:    tol_q <= cfg_data[TolW-1:0];
				default: ;
			endcase
		end
	end

	logic signed [AW-1:0] p1x, p2x, p1y, p2y;
	assign p1x = (c1x_q > (XW'(1) << FRAC_BITS)) ? ONE : AW'(signed'({1'b0, c1x_q}));
	assign p2x = (c2x_q > (XW'(1) << FRAC_BITS)) ? ONE : AW'(signed'({1'b0, c2x_q}));
	assign p1y = AW'(signed'(c1y_q));
	assign p2y = AW'(signed'(c2y_q));

	state_t state_q, state_d;
	logic signed [AW-1:0] u_q, t_q, ss_q, tt_q, st_q, b1_q, b2_q, b3_q, acc_q, dx_q, f_q;
	logic [IterW-1:0] cnt_q, lim_q;
	logic final_q;
	logic [NW-1:0] num_q, quo_q, rem_q, den_q;
	logic [DCW-1:0] dcnt_q;
	logic negq_q;
	logic [YW-1:0] ey_q;
	logic [XW-1:0] ct_q;
	logic mv_q;

	// shared multiplier with round-half-up floor shift
	logic signed [AW-1:0] ma, mb, mr;
	logic signed [PW-1:0] mp;
	assign mp = (PW'(ma) * PW'(mb)) + (PW'(1) <<< (FRAC_BITS - 1));
	assign mr = AW'(mp >>> FRAC_BITS);

	logic signed [AW-1:0] s_w;
	assign s_w = ONE - t_q;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_SS: begin ma = s_w;  mb = s_w; end
			ST_TT: begin ma = t_q;  mb = t_q; end
			ST_ST: begin ma = s_w;  mb = t_q; end
			ST_B1: begin ma = ss_q; mb = t_q; end
			ST_B2: begin ma = s_w;  mb = tt_q; end
			ST_B3: begin ma = tt_q; mb = t_q; end
			ST_X1: begin ma = b1_q; mb = p1x; end
			ST_X2: begin ma = b2_q; mb = p2x; end
			ST_D1: begin ma = p1x;  mb = ss_q - (st_q <<< 1); end
			ST_D2: begin ma = p2x;  mb = (st_q <<< 1) - tt_q; end
			ST_Y1: begin ma = b1_q; mb = p1y; end
			ST_Y2: begin ma = b2_q; mb = p2y; end
			default: ;
		endcase
	end

	logic signed [AW-1:0] af;
	logic stop_w;
	assign af = f_q[AW-1] ? -f_q : f_q;
	assign stop_w = (af < AW'(signed'({1'b0, tol_q}))) || (dx_q == '0);

	logic [NW:0] rtry;
	assign rtry = {rem_q, num_q[NW-1]} - {1'b0, den_q};

	logic signed [AW-1:0] ysat;
	logic signed [NW:0] tn;
	logic signed [NW:0] qs;
	assign qs = negq_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
	// full width so that a large step clamps instead of wrapping
	assign tn = (NW+1)'(t_q) - qs;
	assign ysat = (acc_q > YMAX) ? YMAX : ((acc_q < YMIN) ? YMIN : acc_q);

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) state_d = ST_SS;
			ST_SS:   state_d = ST_TT;
			ST_TT:   state_d = final_q ? ST_B1 : ST_ST;
			ST_ST:   state_d = ST_B1;
			ST_B1:   state_d = ST_B2;
			ST_B2:   state_d = ST_B3;
			ST_B3:   state_d = final_q ? ST_Y1 : ST_X1;
			ST_X1:   state_d = ST_X2;
			ST_X2:   state_d = ST_D1;
			ST_D1:   state_d = ST_D2;
			ST_D2:   state_d = ST_CHK;
			ST_CHK:  state_d = stop_w ? ST_SS : ST_DIV;
			ST_DIV:  if (dcnt_q == DCW'(1)) state_d = ST_UPD;
			ST_UPD:  state_d = ST_SS;
			ST_Y1:   state_d = ST_Y2;
			ST_Y2:   state_d = ST_YSUM;
			// hold while the previous word still waits in the output register
			ST_YSUM: if (!mv_q || m_tready) state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	logic signed [AW-1:0] u_in;
	assign u_in = (s_tdata[XW-1:0] >= (XW'(1) << FRAC_BITS)) ? ONE
		: AW'(signed'({1'b0, s_tdata[XW-1:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
			final_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (state_q == ST_OUT) mv_q <= 1'b1;
			else if (m_tvalid && m_tready) mv_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					cnt_q <= '0;
					lim_q <= (iters_q > MAXI) ? MAXI : iters_q;
					u_q <= u_in;
					t_q <= u_in;
					final_q <= (u_in == '0) || (u_in == ONE) || (iters_q == '0);
				end
				ST_SS: ss_q <= mr;
				ST_TT: tt_q <= mr;
				ST_ST: st_q <= mr;
				ST_B1: b1_q <= AW'(mr * 3);
				ST_B2: b2_q <= AW'(mr * 3);
				ST_B3: begin b3_q <= mr; acc_q <= mr; end
				ST_X1: acc_q <= acc_q + mr;
				ST_X2: begin f_q <= acc_q + mr - u_q; acc_q <= tt_q; end
				ST_D1: acc_q <= acc_q + mr;
				ST_D2: dx_q <= AW'((acc_q + mr) * 3);
				ST_CHK: begin
					if (stop_w) final_q <= 1'b1;
					else begin
						// magnitude divide: |f|<<F / |dx|
						num_q <= NW'(af) << FRAC_BITS;
						den_q <= NW'(dx_q[AW-1] ? -dx_q : dx_q);
						rem_q <= '0;
						quo_q <= '0;
						dcnt_q <= DCW'(NW);
						negq_q <= f_q[AW-1] ^ dx_q[AW-1];
					end
				end
				ST_DIV: begin
					num_q <= num_q << 1;
					dcnt_q <= dcnt_q - DCW'(1);
					if (!rtry[NW]) begin
						rem_q <= rtry[NW-1:0];
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[NW-2:0], num_q[NW-1]};
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
				end
				ST_UPD: begin
					t_q <= (tn < 0) ? '0 : ((tn > ONE) ? ONE : AW'(tn));
					cnt_q <= cnt_q + IterW'(1);
					if (cnt_q + IterW'(1) >= lim_q) final_q <= 1'b1;
				end
				ST_Y1: acc_q <= b3_q + mr;
				ST_Y2: acc_q <= acc_q + mr;
				ST_OUT: begin
					ey_q <= ysat[YW-1:0];
					ct_q <= t_q[XW-1:0];
					final_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata = OUTW'({ct_q, ey_q});
endmodule

// ----- design/cbe_checker.sv -----
// Port-level checker for the easing evaluator, bound to the top level.
module cbe_props (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [39:0] m_tdata
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted a word while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped or changed while stalled");
	a_t: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:18] <= 17'h10000))
		else $error("curve parameter out of range");
endmodule

bind cubic_bezier_easing_eval_unit cbe_props u_cbe_props (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
